// ===== rtl/pixel_color_classifier_top_assert.svh =====
// Assertion macros for the pixel color classifier.
`ifndef PIXEL_COLOR_CLASSIFIER_TOP_ASSERT_SVH
`define PIXEL_COLOR_CLASSIFIER_TOP_ASSERT_SVH
// Implication that holds every clock edge outside reset.
`define PCC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication outside reset.
`define PCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/pcc_pkg.sv =====
// Shared types, class codes and palette for the pixel color classifier.
`default_nettype none
package pcc_pkg;
  typedef enum logic [3:0] {
    CL_BLACK = 4'd0, CL_WHITE = 4'd1, CL_RED = 4'd2, CL_GREEN = 4'd3, CL_BLUE = 4'd4,
    CL_YELLOW = 4'd5, CL_BLUEGREEN = 4'd6, CL_LAV = 4'd7, CL_MAG = 4'd8,
    CL_GRAY = 4'd9, CL_NONE = 4'd10
  } class_t;

  typedef enum logic [1:0] {
    CF_UNRELIABLE = 2'd0, CF_GOOD = 2'd1, CF_CERTAIN = 2'd2
  } conf_t;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
    logic       frame_end;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic [3:0] color_class;
    logic [3:0] second_class;
    logic [1:0] confidence;
    logic       frame_end_out;
  } pix_out_t;

  // hn up to 360*255, hd up to 255
  typedef struct packed {
    logic [16:0] hn;
    logic        achrom;
    logic [7:0]  hd;
    logic [7:0]  mx;
    logic [7:0]  dl;
    logic [7:0]  alpha;
    logic        frame_end;
  } hsv_t;

  // Comparison flags, one per threshold test of the tree.
  typedef struct packed {
    logic v_lt30, v_gt20, v_gt80, v_gt70, v_gt60, v_lt65, v_lt70, v_lt50, v_gt40;
    logic v_lt60, v_lt35, v_gt75;
    logic s_gt30, s_gt60, s_gt80, s_lt20, s_lt10, s_lt5, s_gt10, s_lt15, s_lt30;
    logic s_lt8, s_lt40, s_lt60, s_lt50;
    logic h_ge65, h_le170, h_lt40, h_gt10, h_lt30, h_gt330, h_le30, h_gt20, h_gt80;
    logic h_lt170, h_gt160, h_gt185, h_lt270, h_ge30, h_le80, h_ge70, h_ge150;
    logic h_le185, h_ge180, h_ge270, h_le330, h_lt280;
  } flags_t;

  function automatic logic [23:0] palette(input logic [3:0] c);
    case (c)
      CL_BLACK:     palette = {8'd0, 8'd0, 8'd0};
      CL_WHITE:     palette = {8'd255, 8'd255, 8'd255};
      CL_RED:       palette = {8'd255, 8'd0, 8'd0};
      CL_GREEN:     palette = {8'd0, 8'd255, 8'd0};
      CL_BLUE:      palette = {8'd0, 8'd0, 8'd255};
      CL_YELLOW:    palette = {8'd255, 8'd255, 8'd0};
      CL_BLUEGREEN: palette = {8'd0, 8'd235, 8'd217};
      CL_LAV:       palette = {8'd170, 8'd0, 8'd255};
      CL_MAG:       palette = {8'd255, 8'd0, 8'd255};
      CL_GRAY:      palette = {8'd127, 8'd127, 8'd127};
      default:      palette = {8'd154, 8'd115, 8'd86};
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== rtl/pcc_hsv.sv =====
// Stage 1: max, min, delta and hue fraction of a pixel.
`default_nettype none
module pcc_hsv (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire pcc_pkg::pix_in_t pix,
  output pcc_pkg::hsv_t        hsv_r
);
  logic [7:0] r, g, b, mx, mn, dl;
  logic signed [18:0] hn;
  pcc_pkg::hsv_t hsv_nxt;
  always_comb begin
    r = pix.red_in; g = pix.green_in; b = pix.blue_in;
    mx = (r > g) ? r : g;
    mn = (r > g) ? g : r;
    if (b > mx) mx = b;
    if (b < mn) mn = b;
    dl = mx - mn;
    if (r == mx) hn = 19'sd60 * ($signed({11'd0, g}) - $signed({11'd0, b}));
    else if (g == mx) hn = 19'sd120 * $signed({11'd0, dl})
                          + 19'sd60 * ($signed({11'd0, b}) - $signed({11'd0, r}));
    else hn = 19'sd240 * $signed({11'd0, dl})
              + 19'sd60 * ($signed({11'd0, r}) - $signed({11'd0, g}));
    if (hn < 0) hn = hn + 19'sd360 * $signed({11'd0, dl});
    hsv_nxt.hn = hn[16:0];
    hsv_nxt.achrom = (dl == 8'd0);
    hsv_nxt.hd = dl;
    hsv_nxt.mx = mx;
    hsv_nxt.dl = dl;
    hsv_nxt.alpha = pix.alpha_in;
    hsv_nxt.frame_end = pix.frame_end;
  end
  always_ff @(posedge clk) begin
    if (en) hsv_r <= hsv_nxt;
  end
endmodule
`default_nettype wire

// ===== rtl/pcc_cmp.sv =====
// Stage 2: exact threshold comparisons by cross multiplication.
`default_nettype none
module pcc_cmp (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire pcc_pkg::hsv_t   hsv,
  output pcc_pkg::flags_t      flg_r,
  output logic [7:0]           alpha_r,
  output logic                 fe_r
);
  pcc_pkg::flags_t f;
  logic [15:0] va, sa;
  logic [16:0] hd;

  // hue vs t: achromatic hue counts as below every threshold
  function automatic logic hlt(input logic [16:0] hn, input logic [16:0] d,
                               input logic ach, input int t);
    logic [25:0] b;
    b = 26'(t) * 26'(d);
    hlt = ach || ({9'd0, hn} < b);
  endfunction
  function automatic logic hgt(input logic [16:0] hn, input logic [16:0] d,
                               input logic ach, input int t);
    logic [25:0] b;
    b = 26'(t) * 26'(d);
    hgt = !ach && ({9'd0, hn} > b);
  endfunction

  always_comb begin
    va = 16'(hsv.mx) * 16'd100;
    sa = 16'(hsv.dl) * 16'd100;
    hd = {9'd0, hsv.hd};
    // black pixel: dl is 0, so sa=0 against 0 fails every saturation test until the mx check below
    f.v_lt30 = va < 16'd7650;  f.v_gt20 = va > 16'd5100;
    f.v_gt80 = va > 16'd20400; f.v_gt70 = va > 16'd17850;
    f.v_gt60 = va > 16'd15300; f.v_lt65 = va < 16'd16575;
    f.v_lt70 = va < 16'd17850; f.v_lt50 = va < 16'd12750;
    f.v_gt40 = va > 16'd10200; f.v_lt60 = va < 16'd15300;
    f.v_lt35 = va < 16'd8925;  f.v_gt75 = va > 16'd19125;
    f.s_gt30 = sa > 16'd30 * 16'(hsv.mx); f.s_gt60 = sa > 16'd60 * 16'(hsv.mx);
    f.s_gt80 = sa > 16'd80 * 16'(hsv.mx); f.s_lt20 = sa < 16'd20 * 16'(hsv.mx);
    f.s_lt10 = sa < 16'd10 * 16'(hsv.mx); f.s_lt5  = sa < 16'd5 * 16'(hsv.mx);
    f.s_gt10 = sa > 16'd10 * 16'(hsv.mx); f.s_lt15 = sa < 16'd15 * 16'(hsv.mx);
    f.s_lt30 = sa < 16'd30 * 16'(hsv.mx); f.s_lt8  = sa < 16'd8 * 16'(hsv.mx);
    f.s_lt40 = sa < 16'd40 * 16'(hsv.mx); f.s_lt60 = sa < 16'd60 * 16'(hsv.mx);
    f.s_lt50 = sa < 16'd50 * 16'(hsv.mx);
    // mx of zero: saturation 0, every "below" test is true
    if (hsv.mx == 8'd0) begin
      f.s_lt20 = 1'b1; f.s_lt10 = 1'b1; f.s_lt5 = 1'b1; f.s_lt15 = 1'b1;
      f.s_lt30 = 1'b1; f.s_lt8 = 1'b1; f.s_lt40 = 1'b1; f.s_lt60 = 1'b1;
      f.s_lt50 = 1'b1;
    end
    f.h_ge65  = !hlt(hsv.hn, hd, hsv.achrom, 65);
    f.h_le170 = !hgt(hsv.hn, hd, hsv.achrom, 170);
    f.h_lt40  = hlt(hsv.hn, hd, hsv.achrom, 40);
    f.h_gt10  = hgt(hsv.hn, hd, hsv.achrom, 10);
    f.h_lt30  = hlt(hsv.hn, hd, hsv.achrom, 30);
    f.h_gt330 = hgt(hsv.hn, hd, hsv.achrom, 330);
    f.h_le30  = !hgt(hsv.hn, hd, hsv.achrom, 30);
    f.h_gt20  = hgt(hsv.hn, hd, hsv.achrom, 20);
    f.h_gt80  = hgt(hsv.hn, hd, hsv.achrom, 80);
    f.h_lt170 = hlt(hsv.hn, hd, hsv.achrom, 170);
    f.h_gt160 = hgt(hsv.hn, hd, hsv.achrom, 160);
    f.h_gt185 = hgt(hsv.hn, hd, hsv.achrom, 185);
    f.h_lt270 = hlt(hsv.hn, hd, hsv.achrom, 270);
    f.h_ge30  = !hlt(hsv.hn, hd, hsv.achrom, 30);
    f.h_le80  = !hgt(hsv.hn, hd, hsv.achrom, 80);
    f.h_ge70  = !hlt(hsv.hn, hd, hsv.achrom, 70);
    f.h_ge150 = !hlt(hsv.hn, hd, hsv.achrom, 150);
    f.h_le185 = !hgt(hsv.hn, hd, hsv.achrom, 185);
    f.h_ge180 = !hlt(hsv.hn, hd, hsv.achrom, 180);
    f.h_ge270 = !hlt(hsv.hn, hd, hsv.achrom, 270);
    f.h_le330 = !hgt(hsv.hn, hd, hsv.achrom, 330);
    f.h_lt280 = hlt(hsv.hn, hd, hsv.achrom, 280);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      flg_r <= f;
      alpha_r <= hsv.alpha;
      fe_r <= hsv.frame_end;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/pcc_tree.sv =====
// Stage 3: decision tree over the comparison flags and palette lookup.
`default_nettype none
module pcc_tree (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire pcc_pkg::flags_t f,
  input  wire logic [7:0]      alpha,
  input  wire logic            fe,
  output pcc_pkg::pix_out_t    res_r
);
  logic [3:0] res, sec;
  logic [1:0] cert;
  logic done;
  logic [23:0] pal;
  pcc_pkg::pix_out_t res_nxt;

  always_comb begin
    cert = pcc_pkg::CF_CERTAIN;
    res = pcc_pkg::CL_NONE;
    sec = pcc_pkg::CL_NONE;
    done = 1'b0;
    if (f.v_lt30) begin
      if (f.s_gt30 && f.v_gt20) begin
        sec = pcc_pkg::CL_BLACK;
        if (f.s_gt60 && f.h_ge65 && f.h_le170) begin
          res = pcc_pkg::CL_GREEN; done = 1'b1;
        end else if (f.s_gt80) cert = pcc_pkg::CF_UNRELIABLE;
        else cert = pcc_pkg::CF_GOOD;
      end else begin
        res = pcc_pkg::CL_BLACK; done = 1'b1;
      end
    end else if ((f.v_gt80 && f.s_lt20) || (f.v_gt70 && f.s_lt10) ||
                 (f.v_gt60 && f.s_lt5)) begin
      res = pcc_pkg::CL_WHITE;
      if (f.s_gt10) begin
        cert = pcc_pkg::CF_UNRELIABLE; res = pcc_pkg::CL_NONE; sec = pcc_pkg::CL_WHITE;
      end else begin
        if (f.v_lt70) begin
          sec = pcc_pkg::CL_GRAY; cert = pcc_pkg::CF_GOOD;
        end
        done = 1'b1;
      end
    end else if ((f.v_lt65 && f.s_lt15) || (f.v_lt70 && f.s_lt10) ||
                 (f.v_lt50 && f.s_lt30 && f.h_lt40 && f.h_gt10)) begin
      if (f.v_lt50) begin
        res = pcc_pkg::CL_BLACK; cert = pcc_pkg::CF_GOOD;
        if (f.v_gt40) sec = pcc_pkg::CL_GRAY;
        done = 1'b1;
      end else if (f.s_lt8) begin
        cert = pcc_pkg::CF_GOOD; res = pcc_pkg::CL_WHITE; sec = pcc_pkg::CL_GRAY;
        done = 1'b1;
      end else begin
        cert = pcc_pkg::CF_UNRELIABLE; sec = pcc_pkg::CL_GRAY;
      end
    end
    if (!done) begin
      if (f.h_lt30 || f.h_gt330) begin
        if (f.h_gt10 && f.h_le30 && f.s_lt40) begin
          if (f.h_gt20) begin
            res = pcc_pkg::CL_YELLOW; cert = pcc_pkg::CF_GOOD;
          end else begin
            res = pcc_pkg::CL_RED; cert = pcc_pkg::CF_UNRELIABLE;
          end
          if (f.v_lt70) sec = pcc_pkg::CL_GRAY;
        end else begin
          res = pcc_pkg::CL_RED;
          if (((f.s_lt30 && f.v_lt60) || (f.s_lt40 && f.v_lt35)) &&
              cert == pcc_pkg::CF_CERTAIN) cert = pcc_pkg::CF_GOOD;
        end
      end else if (f.h_gt80 && f.h_lt170) begin
        res = pcc_pkg::CL_GREEN;
        if (f.s_lt20 && cert == pcc_pkg::CF_CERTAIN) cert = pcc_pkg::CF_GOOD;
        if (f.h_gt160 && (f.s_lt60 || f.v_gt60)) begin
          cert = pcc_pkg::CF_UNRELIABLE; sec = pcc_pkg::CL_BLUE;
        end
      end else if (f.h_gt185 && f.h_lt270) begin
        if (f.s_lt30) begin
          if (cert == pcc_pkg::CF_CERTAIN) cert = pcc_pkg::CF_GOOD;
          if (f.v_gt75) begin
            res = pcc_pkg::CL_WHITE; sec = pcc_pkg::CL_BLUE;
          end else begin
            res = pcc_pkg::CL_BLUE;
            sec = f.v_lt60 ? pcc_pkg::CL_GRAY : pcc_pkg::CL_WHITE;
          end
        end else res = pcc_pkg::CL_BLUE;
      end else begin
        if (f.s_lt50) cert = pcc_pkg::CF_UNRELIABLE;
        if (f.h_ge30 && f.h_le80) begin
          res = f.h_ge70 ? pcc_pkg::CL_GREEN : pcc_pkg::CL_YELLOW;
        end else begin
          if (cert == pcc_pkg::CF_CERTAIN) cert = pcc_pkg::CF_GOOD;
          if (f.h_ge150 && f.h_le185) begin
            if (f.h_ge180) res = pcc_pkg::CL_BLUE;
            else if (f.h_lt170) begin
              res = pcc_pkg::CL_GREEN; sec = pcc_pkg::CL_BLUE;
            end else begin
              res = pcc_pkg::CL_BLUE; sec = pcc_pkg::CL_GREEN;
            end
          end else if (f.h_ge270 && f.h_le330) begin
            if (f.h_lt280) begin
              res = pcc_pkg::CL_BLUE;
              if (sec == pcc_pkg::CL_NONE) sec = pcc_pkg::CL_LAV;
            end else begin
              res = pcc_pkg::CL_RED;
              if (sec == pcc_pkg::CL_NONE) sec = pcc_pkg::CL_MAG;
            end
          end
        end
      end
    end
    pal = pcc_pkg::palette((cert == pcc_pkg::CF_CERTAIN) ? res : pcc_pkg::CL_NONE);
    res_nxt.red_out = pal[23:16];
    res_nxt.green_out = pal[15:8];
    res_nxt.blue_out = pal[7:0];
    res_nxt.alpha_out = alpha;
    res_nxt.color_class = res;
    res_nxt.second_class = sec;
    res_nxt.confidence = cert;
    res_nxt.frame_end_out = fe;
  end
  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end
endmodule
`default_nettype wire

// ===== rtl/pixel_color_classifier_top.sv =====
// Three stage registers (HSV, compare, tree) advance together, in that order.
// Throughput: one pixel per cycle while the output is not stalled.
// A stall at the output holds the whole pipeline; nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears the stage valid bits; data needs none.
`default_nettype none
module pixel_color_classifier_top #(
  parameter int RATIO_FRACTION_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire pcc_pkg::pix_in_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output pcc_pkg::pix_out_t  out_data
);
  `include "pixel_color_classifier_top_assert.svh"
  logic [2:0] vld_r, vld_nxt;
  logic adv;
  pcc_pkg::hsv_t hsv;
  pcc_pkg::flags_t flg;
  logic [7:0] alpha2;
  logic fe2;

  // hold everything while the output waits
  assign adv = !(vld_r[2] && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld_r[2];

  pcc_hsv u_hsv (.clk(clk), .en(adv), .pix(in_data), .hsv_r(hsv));
  pcc_cmp u_cmp (.clk(clk), .en(adv), .hsv(hsv), .flg_r(flg), .alpha_r(alpha2),
                 .fe_r(fe2));
  pcc_tree u_tree (.clk(clk), .en(adv), .f(flg), .alpha(alpha2), .fe(fe2),
                   .res_r(out_data));

  always_comb begin
    vld_nxt = adv ? {vld_r[1:0], in_valid} : vld_r;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 3'b000;
    else vld_r <= vld_nxt;
  end

  `PCC_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  `PCC_ASSERT_IMPL(a_nostall, clk, rst_n, !out_valid, !in_stall)
  `PCC_ASSERT_NEXT(a_flow, clk, rst_n, in_valid && !in_stall, vld_r[0])
  `PCC_ASSERT_IMPL(a_conf, clk, rst_n, out_valid, out_data.confidence != 2'd3)
endmodule
`default_nettype wire
